/* design/vita49_packet_deframer_core_macros.svh */
// ----------------------------------------------------------------------------
// VITA-49 deframer assertion macros
// Shared property forms for the checks in the deframer modules.
// ----------------------------------------------------------------------------
`ifndef VITA49_PACKET_DEFRAMER_CORE_MACROS_SVH
`define VITA49_PACKET_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define VPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define VPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/vpd_pkg.sv */
// ----------------------------------------------------------------------------
// VITA-49 deframer package
// Shared types, register map and constants of the packet deframer.
// ----------------------------------------------------------------------------
package vpd_pkg;

	// field widths
	localparam int HDR_W  = 4;
	localparam int SAMP_W = 13;
	localparam int PKT_W  = 14;
	localparam int CNT_W  = 4;
	localparam int WORD_W = 32;
	localparam int IQ_W   = 16;

	// default limits
	localparam int DEF_MAX_PACKET_WORDS = 8192;
	localparam int DEF_MAX_SAMPLES      = 4096;

	// queue between classifier and formatter
	localparam int QUEUE_DEPTH = 4;

	// register map (index = paddr[4:2])
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_HEADER_WORDS = 3'd0;
	localparam logic [2:0] REG_SAMPLES      = 3'd1;
	localparam logic [2:0] REG_PACKET_WORDS = 3'd2;
	localparam logic [2:0] REG_SWAP_BYTES   = 3'd3;
	localparam logic [2:0] REG_SWAP_IQ      = 3'd4;

	// reset values
	localparam logic [HDR_W-1:0]  RST_HEADER_WORDS = 4'd7;
	localparam logic [SAMP_W-1:0] RST_SAMPLES      = 13'd1024;
	localparam logic [PKT_W-1:0]  RST_PACKET_WORDS = 14'd1031;
	localparam logic              RST_SWAP_BYTES   = 1'b1;
	localparam logic              RST_SWAP_IQ      = 1'b0;

	// result kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_DROP   = 1'b1;

	typedef struct packed {
		logic [HDR_W-1:0]  header_words;
		logic [SAMP_W-1:0] samp_per_pkt;
		logic [PKT_W-1:0]  packet_words;
		logic              bswap_en;
		logic              swap_iq;
	} vpd_cfg_t;

	// one classified result waiting for formatting
	typedef struct packed {
		logic              kind;
		logic [WORD_W-1:0] word;
		logic [CNT_W-1:0]  missing;
		logic              last;
	} vpd_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} vpd_qstat_t;

	function automatic logic [IQ_W-1:0] swap16(input logic [IQ_W-1:0] v);
		swap16 = {v[7:0], v[15:8]};
	endfunction

endpackage

/* design/vpd_front.sv */
// ----------------------------------------------------------------------------
// VITA-49 deframer front end
// Tracks word position and packet count, classifies each word and pushes
// the ones that yield a result into the queue.
// ----------------------------------------------------------------------------
module vpd_front import vpd_pkg::*; #(
	parameter int MAX_PACKET_WORDS = DEF_MAX_PACKET_WORDS,
	parameter int MAX_SAMPLES      = DEF_MAX_SAMPLES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vpd_cfg_t          cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [WORD_W-1:0] packet_word,
	input  vpd_qstat_t        qstat,
	output logic              push,
	output vpd_entry_t        push_entry
);

	localparam int PW  = $clog2(MAX_PACKET_WORDS);
	localparam int SW  = $clog2(MAX_SAMPLES + 1);
	localparam int CW0 = (PW > PKT_W) ? PW : PKT_W;
	localparam int CW1 = (CW0 > SW) ? CW0 : SW;
	localparam int CW  = CW1 + 1;

	logic [PW-1:0]    pos_q;
	logic             awaiting_q;
	logic [CNT_W-1:0] expected_q;

	logic             accept;
	logic [CW-1:0]    pos_x, hw_x, len_x, nsamp_x, idx_x, pos_inc;
	logic [CNT_W-1:0] pc, next_cnt;
	logic             is_info, is_sample, is_drop;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		pos_x = CW'(pos_q);
		hw_x  = (cfg.header_words == '0) ? CW'(1) : CW'(cfg.header_words);
		len_x = CW'(cfg.packet_words);
		if (len_x < CW'(2)) begin
			len_x = CW'(2);
		end
		if (len_x > CW'(MAX_PACKET_WORDS)) begin
			len_x = CW'(MAX_PACKET_WORDS);
		end
		nsamp_x = CW'(cfg.samp_per_pkt);
		if (nsamp_x > CW'(MAX_SAMPLES)) begin
			nsamp_x = CW'(MAX_SAMPLES);
		end
		idx_x   = pos_x - hw_x;
		pos_inc = pos_x + CW'(1);

		// count lives in bits 19:16 after the optional 32-bit byte reversal
		pc       = cfg.bswap_en ? packet_word[19:16] : packet_word[11:8];
		next_cnt = expected_q + CNT_W'(1);

		is_info   = (pos_q == '0);
		is_drop   = is_info && !awaiting_q && (next_cnt != pc);
		is_sample = !is_info && (pos_x >= hw_x) && (pos_x < len_x) && (idx_x < nsamp_x);

		push_entry = '0;
		if (is_drop) begin
			push_entry.kind    = KIND_DROP;
			push_entry.missing = pc - next_cnt;
		end else begin
			push_entry.kind = KIND_SAMPLE;
			push_entry.word = packet_word;
			push_entry.last = (idx_x + CW'(1) == nsamp_x);
		end
	end

	assign push = accept && (is_drop || is_sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			awaiting_q <= 1'b1;
			expected_q <= '0;
		end else if (accept) begin
			// wrap at packet end, also when a shorter length was set mid-packet
			pos_q <= (pos_inc >= len_x) ? '0 : PW'(pos_inc);
			if (is_info) begin
				awaiting_q <= 1'b0;
				expected_q <= pc;
			end
		end
	end

endmodule

/* design/vpd_queue.sv */
// ----------------------------------------------------------------------------
// VITA-49 deframer result queue
// Short FIFO of classified results between front end and formatter.
// ----------------------------------------------------------------------------
`include "vita49_packet_deframer_core_macros.svh"

module vpd_queue import vpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  vpd_entry_t push_entry,
	input  logic       pop,
	output vpd_entry_t head,
	output vpd_qstat_t qstat
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	vpd_entry_t    mem [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] count_q;

	assign head        = mem[rd_ptr_q];
	assign qstat.full  = (count_q == NW'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	`VPD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= NW'(QUEUE_DEPTH), "queue count overflow")
	`VPD_ASSERT_NOW(a_pop_nonempty, pop, !qstat.empty, "pop from empty queue")
	`VPD_ASSERT_NEXT(a_push_grows, push && !pop, count_q == $past(count_q) + NW'(1), "push lost")

endmodule

/* design/vpd_back.sv */
// ----------------------------------------------------------------------------
// VITA-49 deframer back end
// Pops classified results, applies byte and I/Q ordering, holds the result
// beat in an output register.
// ----------------------------------------------------------------------------
module vpd_back import vpd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  vpd_cfg_t               cfg,
	input  vpd_qstat_t             qstat,
	input  vpd_entry_t             head,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   result_kind,
	output logic signed [IQ_W-1:0] i_value,
	output logic signed [IQ_W-1:0] q_value,
	output logic [CNT_W-1:0]       missing_packets,
	output logic                   last_sample
);

	logic            valid_q;
	logic [IQ_W-1:0] hi, lo, iv, qv;

	assign pop       = !qstat.empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;

	always_comb begin
		hi = head.word[31:16];
		lo = head.word[15:0];
		iv = cfg.swap_iq ? lo : hi;
		qv = cfg.swap_iq ? hi : lo;
		if (!cfg.bswap_en) begin
			iv = swap16(iv);
			qv = swap16(qv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload loads only on pop, so a stalled beat holds
	always_ff @(posedge clk) begin
		if (pop) begin
			result_kind     <= head.kind;
			i_value         <= iv;
			q_value         <= qv;
			missing_packets <= head.missing;
			last_sample     <= head.last;
		end
	end

endmodule

/* design/vita49_packet_deframer_core.sv */
// Data path: an accepted word's result is written into the queue, then loaded
// into the output register when the back end pops it.
// Throughput: one packet word per cycle; the front end stalls only when the
// four-entry result queue is full, i.e. after sustained output stall.
// Reset (arst_n low, asynchronous): registers to defaults, word position 0,
// queue and output register empty, first packet count awaited.
// ----------------------------------------------------------------------------
// VITA-49 packet deframer core
// Config registers, front-end classifier, result queue and output formatter.
// ----------------------------------------------------------------------------
module vita49_packet_deframer_core import vpd_pkg::*; #(
	parameter int MAX_PACKET_WORDS = DEF_MAX_PACKET_WORDS,
	parameter int MAX_SAMPLES      = DEF_MAX_SAMPLES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [WORD_W-1:0]      packet_word,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   result_kind,
	output logic signed [IQ_W-1:0] i_value,
	output logic signed [IQ_W-1:0] q_value,
	output logic [CNT_W-1:0]       missing_packets,
	output logic                   last_sample
);

	vpd_cfg_t   cfg_q;
	vpd_qstat_t qstat;
	vpd_entry_t push_entry, head;
	logic       push, pop, wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_words <= RST_HEADER_WORDS;
			cfg_q.samp_per_pkt <= RST_SAMPLES;
			cfg_q.packet_words <= RST_PACKET_WORDS;
			cfg_q.bswap_en     <= RST_SWAP_BYTES;
			cfg_q.swap_iq      <= RST_SWAP_IQ;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HEADER_WORDS: cfg_q.header_words <= pwdata[HDR_W-1:0];
				REG_SAMPLES:      cfg_q.samp_per_pkt <= pwdata[SAMP_W-1:0];
				REG_PACKET_WORDS: cfg_q.packet_words <= pwdata[PKT_W-1:0];
				REG_SWAP_BYTES:   cfg_q.bswap_en     <= pwdata[0];
				REG_SWAP_IQ:      cfg_q.swap_iq      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HEADER_WORDS: prdata = 32'(cfg_q.header_words);
			REG_SAMPLES:      prdata = 32'(cfg_q.samp_per_pkt);
			REG_PACKET_WORDS: prdata = 32'(cfg_q.packet_words);
			REG_SWAP_BYTES:   prdata = 32'(cfg_q.bswap_en);
			REG_SWAP_IQ:      prdata = 32'(cfg_q.swap_iq);
			default:          prdata = '0;
		endcase
	end

	vpd_front #(
		.MAX_PACKET_WORDS(MAX_PACKET_WORDS),
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.packet_word(packet_word),
		.qstat(qstat),
		.push(push),
		.push_entry(push_entry)
	);

	vpd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.head(head),
		.qstat(qstat)
	);

	vpd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.qstat(qstat),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.i_value(i_value),
		.q_value(q_value),
		.missing_packets(missing_packets),
		.last_sample(last_sample)
	);

endmodule
